// File: rtl/core/rmbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmbb_pkg
// Types and constants shared by the radio module baud bring-up logic.
// ----------------------------------------------------------------------------
package rmbb_pkg;

  localparam int START_POS_W = 3;
  localparam int OK_POS_W    = 2;
  localparam int BANNER_LEN  = 5;
  localparam int OK_LEN      = 2;

  localparam logic [7:0] BANNER_PAT [BANNER_LEN] = '{8'h53, 8'h74, 8'h61, 8'h72, 8'h74};
  localparam logic [7:0] OK_PAT     [OK_LEN]     = '{8'h4f, 8'h4b};

  localparam logic [15:0] START_TIMEOUT_RST = 16'd1000;
  localparam logic [15:0] AT_TIMEOUT_RST    = 16'd500;
  localparam logic [15:0] RESET_TIMEOUT_RST = 16'd1500;

  typedef enum logic [3:0] {
    PH_WAIT_START = 4'd0,
    PH_PROBE_FAST = 4'd1,
    PH_PROBE_SLOW = 4'd2,
    PH_WAIT_BAUD  = 4'd3,
    PH_WAIT_RESET = 4'd4,
    PH_VERIFY     = 4'd5,
    PH_READY      = 4'd6,
    PH_FAILED     = 4'd7,
    PH_OFF        = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_AT    = 2'd1,
    CMD_BAUD4 = 2'd2,
    CMD_RESET = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REQ_START  = 3'd0,
    REQ_STOP   = 3'd1,
    REQ_RX     = 3'd2,
    REQ_RX_ERR = 3'd3,
    REQ_TICK   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    CFG_START_TIMEOUT = 2'd0,
    CFG_AT_TIMEOUT    = 2'd1,
    CFG_RESET_TIMEOUT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] cmd_code;
    logic       baud_fast;
    logic       module_power;
    logic [3:0] link_phase;
    logic       ready_res;
    logic       finished;
  } out_item_t;

  typedef struct packed {
    logic [15:0] start_timeout_ms;
    logic [15:0] at_timeout_ms;
    logic [15:0] reset_timeout_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic [START_POS_W-1:0] start_pos_nxt;
    logic                   start_hit;
    logic [OK_POS_W-1:0]    ok_pos_nxt;
    logic                   ok_hit;
  } match_t;

endpackage

// File: rtl/core/rmbb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmbb_in_if / rmbb_out_if
// Valid/ready channels for event items and status items.
// ----------------------------------------------------------------------------
interface rmbb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  rx_byte;
  logic [31:0] now_ms;

  modport source (output valid, output req_type, output rx_byte, output now_ms,
                  input ready);
  modport sink   (input valid, input req_type, input rx_byte, input now_ms,
                  output ready);
endinterface

interface rmbb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd_code;
  logic       baud_fast;
  logic       module_power;
  logic [3:0] link_phase;
  logic       ready_res;
  logic       finished;

  modport source (output valid, output cmd_code, output baud_fast, output module_power,
                  output link_phase, output ready_res, output finished, input ready);
  modport sink   (input valid, input cmd_code, input baud_fast, input module_power,
                  input link_phase, input ready_res, input finished, output ready);
endinterface

// File: rtl/core/rmbb_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmbb_match
// Naive byte matchers for the "Start" banner and the "OK" reply.
// ----------------------------------------------------------------------------
module rmbb_match (
  input  logic [7:0]                     rx_byte,
  input  logic [rmbb_pkg::START_POS_W-1:0] start_pos,
  input  logic [rmbb_pkg::OK_POS_W-1:0]    ok_pos,
  output rmbb_pkg::match_t               match
);
  import rmbb_pkg::*;

  logic [START_POS_W-1:0] sp;
  logic [OK_POS_W-1:0]    op;

  always_comb begin
    match = '0;
    sp = (start_pos >= START_POS_W'(BANNER_LEN)) ? '0 : start_pos;
    op = (ok_pos >= OK_POS_W'(OK_LEN)) ? '0 : ok_pos;

    if (rx_byte == BANNER_PAT[sp]) begin
      if (sp == START_POS_W'(BANNER_LEN - 1)) begin
        match.start_hit = 1'b1;
      end else begin
        match.start_pos_nxt = sp + 1'b1;
      end
    end else begin
      // a mismatch may still open a new banner
      match.start_pos_nxt = (rx_byte == BANNER_PAT[0]) ? START_POS_W'(1) : '0;
    end

    if (rx_byte == OK_PAT[op[0]]) begin
      if (op == OK_POS_W'(OK_LEN - 1)) begin
        match.ok_hit = 1'b1;
      end else begin
        match.ok_pos_nxt = op + 1'b1;
      end
    end else begin
      match.ok_pos_nxt = (rx_byte == OK_PAT[0]) ? OK_POS_W'(1) : '0;
    end
  end

endmodule

// File: rtl/core/rmbb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmbb_ctrl
// Bring-up state registers and per-event update, one item per enable.
// ----------------------------------------------------------------------------
module rmbb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  rmbb_pkg::in_item_t   item,
  input  rmbb_pkg::cfg_regs_t  cfg,
  output rmbb_pkg::out_item_t  res
);
  import rmbb_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [31:0]            phase_start_r, phase_start_nxt;
  logic                   start_seen_r, start_seen_nxt;
  logic                   ok_seen_r, ok_seen_nxt;
  logic [START_POS_W-1:0] start_pos_r, start_pos_nxt;
  logic [OK_POS_W-1:0]    ok_pos_r, ok_pos_nxt;
  logic                   fast_r, fast_nxt;
  logic                   power_r, power_nxt;

  match_t      match;
  logic [31:0] elapsed;
  logic [15:0] limit;
  logic        timed_out;
  logic        enter;
  phase_t      enter_ph;
  cmd_t        cmd;

  rmbb_match u_match (
    .rx_byte   (item.rx_byte),
    .start_pos (start_pos_r),
    .ok_pos    (ok_pos_r),
    .match     (match)
  );

  assign elapsed = item.now_ms - phase_start_r;

  always_comb begin
    case (phase_r)
      PH_WAIT_START: limit = cfg.start_timeout_ms;
      PH_WAIT_RESET: limit = cfg.reset_timeout_ms;
      default:       limit = cfg.at_timeout_ms;
    endcase
  end

  assign timed_out = (elapsed >= {16'b0, limit});

  always_comb begin
    phase_nxt       = phase_r;
    phase_start_nxt = phase_start_r;
    start_seen_nxt  = start_seen_r;
    ok_seen_nxt     = ok_seen_r;
    start_pos_nxt   = start_pos_r;
    ok_pos_nxt      = ok_pos_r;
    fast_nxt        = fast_r;
    power_nxt       = power_r;
    enter           = 1'b0;
    enter_ph        = phase_r;
    cmd             = CMD_NONE;

    unique case (item.req_type)
      REQ_START: begin
        phase_nxt       = PH_WAIT_START;
        phase_start_nxt = item.now_ms;
        start_seen_nxt  = 1'b0;
        ok_seen_nxt     = 1'b0;
        start_pos_nxt   = '0;
        ok_pos_nxt      = '0;
        fast_nxt        = 1'b1;
        power_nxt       = 1'b1;
      end
      REQ_STOP: begin
        power_nxt = 1'b0;
        phase_nxt = PH_OFF;
      end
      REQ_RX: begin
        if (phase_r != PH_OFF) begin
          start_pos_nxt = match.start_pos_nxt;
          ok_pos_nxt    = match.ok_pos_nxt;
          // the banner only counts at fast baud
          if (match.start_hit && fast_r) start_seen_nxt = 1'b1;
          if (match.ok_hit) ok_seen_nxt = 1'b1;
        end
      end
      REQ_RX_ERR: begin
        if (phase_r != PH_OFF) begin
          start_pos_nxt = '0;
          ok_pos_nxt    = '0;
        end
      end
      REQ_TICK: begin
        unique case (phase_r)
          PH_WAIT_START, PH_PROBE_FAST, PH_VERIFY: begin
            if (start_seen_r || (phase_r != PH_WAIT_START && ok_seen_r)) begin
              phase_nxt = PH_READY;
            end else if (timed_out) begin
              unique case (phase_r)
                PH_WAIT_START: begin
                  enter    = 1'b1;
                  enter_ph = PH_PROBE_FAST;
                  cmd      = CMD_AT;
                end
                PH_PROBE_FAST: begin
                  fast_nxt = 1'b0;
                  enter    = 1'b1;
                  enter_ph = PH_PROBE_SLOW;
                  cmd      = CMD_AT;
                end
                default: begin
                  fast_nxt  = 1'b1;
                  phase_nxt = PH_FAILED;
                end
              endcase
            end
          end
          PH_PROBE_SLOW, PH_WAIT_BAUD: begin
            if (ok_seen_r) begin
              enter = 1'b1;
              if (phase_r == PH_PROBE_SLOW) begin
                enter_ph = PH_WAIT_BAUD;
                cmd      = CMD_BAUD4;
              end else begin
                enter_ph = PH_WAIT_RESET;
                cmd      = CMD_RESET;
                fast_nxt = 1'b1;
              end
            end else if (timed_out) begin
              fast_nxt  = 1'b1;
              phase_nxt = PH_FAILED;
            end
          end
          PH_WAIT_RESET: begin
            if (start_seen_r) begin
              phase_nxt = PH_READY;
            end else if (timed_out) begin
              enter    = 1'b1;
              enter_ph = PH_VERIFY;
              cmd      = CMD_AT;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    if (enter) begin
      phase_nxt       = enter_ph;
      phase_start_nxt = item.now_ms;
      ok_seen_nxt     = 1'b0;
      ok_pos_nxt      = '0;
      // a banner already seen carries into the fast-baud checks
      if (enter_ph != PH_PROBE_FAST && enter_ph != PH_VERIFY) begin
        start_seen_nxt = 1'b0;
        start_pos_nxt  = '0;
      end
    end
  end

  always_comb begin
    res.cmd_code     = cmd;
    res.baud_fast    = fast_nxt;
    res.module_power = power_nxt;
    res.link_phase   = phase_nxt;
    res.ready_res    = (phase_nxt == PH_READY);
    res.finished     = (phase_nxt inside {PH_READY, PH_FAILED, PH_OFF});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_OFF;
      phase_start_r <= '0;
      start_seen_r  <= 1'b0;
      ok_seen_r     <= 1'b0;
      start_pos_r   <= '0;
      ok_pos_r      <= '0;
      fast_r        <= 1'b1;
      power_r       <= 1'b0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      phase_start_r <= phase_start_nxt;
      start_seen_r  <= start_seen_nxt;
      ok_seen_r     <= ok_seen_nxt;
      start_pos_r   <= start_pos_nxt;
      ok_pos_r      <= ok_pos_nxt;
      fast_r        <= fast_nxt;
      power_r       <= power_nxt;
    end
  end

endmodule

// File: rtl/core/radio_module_baud_bringup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_module_baud_bringup_core
// Serial radio module bring-up controller: one status item per event item.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_ch   | in  | valid/ready        | req_type, rx_byte, now_ms
//  out_ch  | out | valid/ready        | cmd_code, baud_fast, module_power,
//          |     |                    | link_phase, ready_res, finished
//  cfg_*   | in  | cfg_we, no wait    | cfg_idx, cfg_wdata (16 bit)
//
// an item in the input register is registered through rmbb_ctrl into the result
// register once that register is free; one item per cycle is sustained while
// the output is not stalled.
// in_ch.ready stays high while the result register is free or being taken.
// synchronous reset clears state to the off phase and restores the timeouts.
// a stalled output holds its item and the input register holds the next one.
// ----------------------------------------------------------------------------
module radio_module_baud_bringup_core (
  input  logic        clk,
  input  logic        rst_n,
  rmbb_in_if.sink     in_ch,
  rmbb_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);
  import rmbb_pkg::*;

  in_item_t  s1_item_r;
  logic      s1_valid_r;
  out_item_t out_item_r;
  logic      out_valid_r;
  out_item_t res;
  cfg_regs_t cfg_r;
  logic      out_free;
  logic      advance;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_timeout_ms <= START_TIMEOUT_RST;
      cfg_r.at_timeout_ms    <= AT_TIMEOUT_RST;
      cfg_r.reset_timeout_ms <= RESET_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_START_TIMEOUT: cfg_r.start_timeout_ms <= cfg_wdata;
        CFG_AT_TIMEOUT:    cfg_r.at_timeout_ms    <= cfg_wdata;
        CFG_RESET_TIMEOUT: cfg_r.reset_timeout_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r.req_type <= in_ch.req_type;
      s1_item_r.rx_byte  <= in_ch.rx_byte;
      s1_item_r.now_ms   <= in_ch.now_ms;
    end
  end

  rmbb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.cmd_code     = out_item_r.cmd_code;
  assign out_ch.baud_fast    = out_item_r.baud_fast;
  assign out_ch.module_power = out_item_r.module_power;
  assign out_ch.link_phase   = out_item_r.link_phase;
  assign out_ch.ready_res    = out_item_r.ready_res;
  assign out_ch.finished     = out_item_r.finished;

  // a command is only issued while bring-up is still running
  a_cmd_not_finished: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.cmd_code != CMD_NONE) |-> !out_ch.finished)
    else $error("command issued in a finished phase");

  // the baud change command goes out at slow baud
  a_baud4_slow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.cmd_code == CMD_BAUD4) |-> !out_ch.baud_fast)
    else $error("baud command sent at fast baud");

  // powered down means the off phase
  a_power_off_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.module_power) |-> (out_ch.link_phase == PH_OFF))
    else $error("module unpowered outside the off phase");

  // the result register is only overwritten when it was free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_item_r)))
    else $error("pending item lost");

endmodule

// File: bench/radio_module_baud_bringup_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_module_baud_bringup_core_test
// Self-checking bench for the radio module baud bring-up core. Event items
// are driven on the input channel; a behavioral model of the bring-up phases
// predicts one status item per event, and every status item is checked field
// by field. Directed event sequences come first, then random bring-up
// sessions over a range of timeout settings, with random gaps and stalls.
// ----------------------------------------------------------------------------
module radio_module_baud_bringup_core_test;
  import rmbb_pkg::*;

  localparam int          STALL_LIMIT    = 2000;
  localparam logic [2:0]  REQ_UNDEF_LO   = 3'd5;
  localparam logic [2:0]  REQ_UNDEF_HI   = 3'd7;
  localparam logic [1:0]  CFG_IDX_UNUSED = 2'd3;
  localparam logic [15:0] SWEEP_TMO [4][3] = '{
    '{16'd0,     16'd0,     16'd0},
    '{16'hffff,  16'hffff,  16'hffff},
    '{16'd1,     16'hffff,  16'd0},
    '{16'hffff,  16'd0,     16'd2}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_idx    = 2'd0;
  logic [15:0] cfg_wdata  = 16'd0;
  logic        sink_ready = 1'b0;

  rmbb_in_if  ev_ch ();
  rmbb_out_if st_ch ();

  assign st_ch.ready = sink_ready;

  radio_module_baud_bringup_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (ev_ch),
    .out_ch    (st_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // timeouts as the block should hold them
  logic [15:0] start_tmo = START_TIMEOUT_RST;
  logic [15:0] at_tmo    = AT_TIMEOUT_RST;
  logic [15:0] reset_tmo = RESET_TIMEOUT_RST;

  // link state as the block should hold it
  phase_t      lk_phase    = PH_OFF;
  logic [31:0] lk_t0       = 32'd0;
  logic        banner_seen = 1'b0;
  logic        ok_seen     = 1'b0;
  logic [2:0]  banner_pos  = 3'd0;
  logic [1:0]  ok_pos      = 2'd0;
  logic        fast_sel    = 1'b1;
  logic        power_on    = 1'b0;

  out_item_t   status_q [$];
  int          sent_count  = 0;
  int          done_count  = 0;
  int          err_count   = 0;
  int          idle_cycles = 0;
  int          stall_left  = 0;
  bit          idle_mode   = 1'b0;
  logic [31:0] clock_ms    = 32'd0;

  // returns {hit, next position}
  function automatic logic [3:0] next_match(input logic [7:0] b, input bit banner,
                                            input logic [2:0] pos);
    int         len;
    int         p;
    logic [7:0] hit_char;
    logic [7:0] first;
    len = banner ? BANNER_LEN : OK_LEN;
    p = (pos >= len) ? 0 : int'(pos);
    if (banner) begin
      hit_char = BANNER_PAT[p];
      first    = BANNER_PAT[0];
    end else begin
      hit_char = OK_PAT[p];
      first    = OK_PAT[0];
    end
    if (b == hit_char) begin
      p++;
      return (p >= len) ? 4'b1000 : {1'b0, 3'(p)};
    end
    return {1'b0, (b == first) ? 3'd1 : 3'd0};
  endfunction

  function automatic void advance_phase(input phase_t nxt, input logic [31:0] now);
    lk_phase = nxt;
    lk_t0    = now;
    ok_seen  = 1'b0;
    ok_pos   = 2'd0;
    // the banner flag survives into the fast probe and the verify phase
    if (nxt != PH_PROBE_FAST && nxt != PH_VERIFY) begin
      banner_seen = 1'b0;
      banner_pos  = 3'd0;
    end
  endfunction

  function automatic void mark_failed();
    fast_sel = 1'b1;
    lk_phase = PH_FAILED;
  endfunction

  function automatic cmd_t tick_step(input logic [31:0] now);
    logic [31:0] el;
    el = now - lk_t0;
    case (lk_phase)
      PH_WAIT_START, PH_PROBE_FAST, PH_VERIFY: begin
        if (banner_seen || (lk_phase != PH_WAIT_START && ok_seen)) begin
          lk_phase = PH_READY;
        end else if (lk_phase == PH_WAIT_START && el >= start_tmo) begin
          advance_phase(PH_PROBE_FAST, now);
          return CMD_AT;
        end else if (lk_phase == PH_PROBE_FAST && el >= at_tmo) begin
          fast_sel = 1'b0;
          advance_phase(PH_PROBE_SLOW, now);
          return CMD_AT;
        end else if (lk_phase == PH_VERIFY && el >= at_tmo) begin
          mark_failed();
        end
      end
      PH_PROBE_SLOW: begin
        if (ok_seen) begin
          advance_phase(PH_WAIT_BAUD, now);
          return CMD_BAUD4;
        end
        if (el >= at_tmo) mark_failed();
      end
      PH_WAIT_BAUD: begin
        if (ok_seen) begin
          advance_phase(PH_WAIT_RESET, now);
          fast_sel = 1'b1;
          return CMD_RESET;
        end
        if (el >= at_tmo) mark_failed();
      end
      PH_WAIT_RESET: begin
        if (banner_seen) begin
          lk_phase = PH_READY;
        end else if (el >= reset_tmo) begin
          advance_phase(PH_VERIFY, now);
          return CMD_AT;
        end
      end
      default: ;
    endcase
    return CMD_NONE;
  endfunction

  function automatic out_item_t predict_status(input logic [2:0] req, input logic [7:0] b,
                                               input logic [31:0] now);
    out_item_t  r;
    cmd_t       cmd;
    logic [3:0] m;
    cmd = CMD_NONE;
    case (req)
      REQ_START: begin
        lk_phase    = PH_WAIT_START;
        lk_t0       = now;
        banner_seen = 1'b0;
        ok_seen     = 1'b0;
        banner_pos  = 3'd0;
        ok_pos      = 2'd0;
        fast_sel    = 1'b1;
        power_on    = 1'b1;
      end
      REQ_STOP: begin
        power_on = 1'b0;
        lk_phase = PH_OFF;
      end
      REQ_RX: begin
        // receiver is not running while off
        if (lk_phase != PH_OFF) begin
          m = next_match(b, 1'b1, banner_pos);
          banner_pos = m[2:0];
          if (m[3] && fast_sel) banner_seen = 1'b1;
          m = next_match(b, 1'b0, {1'b0, ok_pos});
          ok_pos = m[1:0];
          if (m[3]) ok_seen = 1'b1;
        end
      end
      REQ_RX_ERR: begin
        if (lk_phase != PH_OFF) begin
          banner_pos = 3'd0;
          ok_pos     = 2'd0;
        end
      end
      REQ_TICK: cmd = tick_step(now);
      default: ;
    endcase
    r.cmd_code     = cmd;
    r.baud_fast    = fast_sel;
    r.module_power = power_on;
    r.link_phase   = lk_phase;
    r.ready_res    = (lk_phase == PH_READY);
    r.finished     = (lk_phase == PH_READY || lk_phase == PH_FAILED || lk_phase == PH_OFF);
    return r;
  endfunction

  function automatic logic [15:0] rand_timeout();
    case ($urandom_range(0, 3))
      0, 1:    return 16'($urandom_range(0, 20));
      2:       return 16'($urandom_range(100, 2000));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // result sink with random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      sink_ready <= 1'b0;
      stall_left--;
    end else if (idle_mode && $urandom_range(0, 9) == 0) begin
      sink_ready <= 1'b0;
      stall_left = $urandom_range(0, 13);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : status_check
    out_item_t want;
    if (rst_n) begin
      if (st_ch.valid && st_ch.ready) begin
        done_count++;
        if (status_q.size() == 0) begin
          $error("status item arrived with nothing expected");
          err_count++;
        end else begin
          want = status_q.pop_front();
          if (st_ch.cmd_code !== want.cmd_code) begin
            $error("cmd_code: expected %0d, got %0d", want.cmd_code, st_ch.cmd_code);
            err_count++;
          end
          if (st_ch.baud_fast !== want.baud_fast) begin
            $error("baud_fast: expected %0d, got %0d", want.baud_fast, st_ch.baud_fast);
            err_count++;
          end
          if (st_ch.module_power !== want.module_power) begin
            $error("module_power: expected %0d, got %0d", want.module_power,
                   st_ch.module_power);
            err_count++;
          end
          if (st_ch.link_phase !== want.link_phase) begin
            $error("link_phase: expected %0d, got %0d", want.link_phase, st_ch.link_phase);
            err_count++;
          end
          if (st_ch.ready_res !== want.ready_res) begin
            $error("ready_res: expected %0d, got %0d", want.ready_res, st_ch.ready_res);
            err_count++;
          end
          if (st_ch.finished !== want.finished) begin
            $error("finished: expected %0d, got %0d", want.finished, st_ch.finished);
            err_count++;
          end
        end
      end
      if (ev_ch.valid && ev_ch.ready)
        status_q.push_back(predict_status(ev_ch.req_type, ev_ch.rx_byte, ev_ch.now_ms));
    end
  end

  always @(posedge clk) begin
    if ((ev_ch.valid && ev_ch.ready) || (st_ch.valid && st_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // valid stays high from one item to the next unless a gap is taken
  task automatic send_event(input logic [2:0] req, input logic [7:0] b,
                            input logic [31:0] now);
    if (idle_mode && $urandom_range(0, 7) == 0) begin
      ev_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    ev_ch.valid    <= 1'b1;
    ev_ch.req_type <= req;
    ev_ch.rx_byte  <= b;
    ev_ch.now_ms   <= now;
    do @(posedge clk); while (ev_ch.ready !== 1'b1);
    sent_count++;
  endtask

  task automatic send_pattern(input bit banner, input int count);
    for (int i = 0; i < count; i++)
      send_event(REQ_RX, banner ? BANNER_PAT[i] : OK_PAT[i % OK_LEN], $urandom());
  endtask

  task automatic settle_block();
    ev_ch.valid <= 1'b0;
    while (done_count < sent_count) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_timeouts(input logic [15:0] s, input logic [15:0] a,
                               input logic [15:0] r, input bit poke_unused);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_START_TIMEOUT;
    cfg_wdata <= s;
    @(posedge clk);
    start_tmo = s;
    cfg_idx   <= CFG_AT_TIMEOUT;
    cfg_wdata <= a;
    @(posedge clk);
    at_tmo = a;
    cfg_idx   <= CFG_RESET_TIMEOUT;
    cfg_wdata <= r;
    @(posedge clk);
    reset_tmo = r;
    // writes to the spare index must not land anywhere
    if (poke_unused) begin
      cfg_idx   <= CFG_IDX_UNUSED;
      cfg_wdata <= 16'($urandom());
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // one bring-up attempt: ticks stepped around the timeouts, replies mixed in
  task automatic run_session(input int steps);
    logic [15:0] tmo;
    logic [31:0] step_ms;
    int          pick;
    clock_ms = $urandom();
    send_event(REQ_START, 8'($urandom()), clock_ms);
    for (int k = 0; k < steps; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 2))
          0:       tmo = start_tmo;
          1:       tmo = at_tmo;
          default: tmo = reset_tmo;
        endcase
        case ($urandom_range(0, 5))
          0:       step_ms = 32'd0;
          1:       step_ms = tmo - 1;
          2, 3:    step_ms = tmo;
          4:       step_ms = $urandom_range(0, tmo);
          default: step_ms = $urandom();
        endcase
        clock_ms += step_ms;
        send_event(REQ_TICK, 8'($urandom()), clock_ms);
      end else if (pick < 60) begin
        send_pattern(1'b0, OK_LEN);
      end else if (pick < 70) begin
        send_pattern(1'b1, BANNER_LEN);
      end else if (pick < 76) begin
        send_pattern(1'b1, $urandom_range(1, BANNER_LEN - 1));
      end else if (pick < 84) begin
        send_event(REQ_RX, 8'($urandom()), $urandom());
      end else if (pick < 89) begin
        send_event(REQ_RX_ERR, 8'($urandom()), $urandom());
      end else if (pick < 92) begin
        send_event(3'($urandom_range(REQ_UNDEF_LO, REQ_UNDEF_HI)), 8'($urandom()),
                   $urandom());
      end else if (pick < 96) begin
        clock_ms += $urandom_range(0, 50);
        send_event(REQ_START, 8'($urandom()), clock_ms);
      end else begin
        send_event(REQ_STOP, 8'($urandom()), $urandom());
      end
    end
  endtask

  task automatic test_events_while_off();
    send_event(REQ_TICK, 8'h00, 32'h0000_0000);
    send_event(REQ_RX, 8'hff, 32'hffff_ffff);
    send_event(REQ_RX_ERR, 8'h00, 32'h0000_0000);
    send_event(REQ_UNDEF_HI, 8'hff, 32'hffff_ffff);
  endtask

  // no reply at fast baud, answer at slow baud, then the verify times out
  task automatic test_slow_rate_path();
    logic [31:0] t0;
    t0 = 32'hffff_fe00;
    send_event(REQ_START, 8'h00, t0);
    send_pattern(1'b1, 2);
    send_event(REQ_RX_ERR, 8'h00, t0);
    send_event(REQ_RX, BANNER_PAT[2], t0);
    send_event(REQ_TICK, 8'h00, t0 + 999);
    send_event(REQ_TICK, 8'h00, t0 + 1000);
    send_event(REQ_TICK, 8'h00, t0 + 1500);
    // banner at slow baud does not count
    send_pattern(1'b1, BANNER_LEN);
    send_pattern(1'b0, OK_LEN);
    send_event(REQ_TICK, 8'h00, t0 + 1501);
    send_pattern(1'b0, OK_LEN);
    send_event(REQ_TICK, 8'h00, t0 + 1502);
    send_event(REQ_TICK, 8'h00, t0 + 3002);
    send_event(REQ_TICK, 8'h00, t0 + 3502);
    send_pattern(1'b0, OK_LEN);
    send_event(REQ_TICK, 8'hff, t0 + 3600);
    send_event(REQ_STOP, 8'hff, 32'hffff_ffff);
    send_event(REQ_UNDEF_LO, 8'h00, 32'h0000_0000);
  endtask

  task automatic test_timeout_sweep();
    int goal;
    for (int s = 0; s < 6; s++) begin
      settle_block();
      if (s < 4) load_timeouts(SWEEP_TMO[s][0], SWEEP_TMO[s][1], SWEEP_TMO[s][2], s == 2);
      else load_timeouts(rand_timeout(), rand_timeout(), rand_timeout(), 1'b0);
      idle_mode = (s % 2 == 0);
      goal = sent_count + 90;
      while (sent_count < goal) run_session($urandom_range(10, 40));
    end
  endtask

  task automatic test_random_bringup();
    int goal;
    while (sent_count < 1050) begin
      settle_block();
      load_timeouts(rand_timeout(), rand_timeout(), rand_timeout(), 1'b0);
      idle_mode = ($urandom_range(0, 3) != 0);
      goal = sent_count + 150;
      while (sent_count < goal) run_session($urandom_range(10, 40));
    end
    // full rate to the end
    settle_block();
    idle_mode = 1'b0;
    load_timeouts(START_TIMEOUT_RST, AT_TIMEOUT_RST, RESET_TIMEOUT_RST, 1'b0);
    while (sent_count < 1250) run_session($urandom_range(10, 40));
  endtask

  initial begin
    ev_ch.valid    <= 1'b0;
    ev_ch.req_type <= REQ_TICK;
    ev_ch.rx_byte  <= 8'h00;
    ev_ch.now_ms   <= 32'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    idle_mode = 1'b1;
    test_events_while_off();
    test_slow_rate_path();
    test_timeout_sweep();
    test_random_bringup();
    settle_block();
    repeat (4) @(posedge clk);
    if (err_count == 0 && status_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/rmbb_pkg.sv
rtl/core/rmbb_if.sv
rtl/core/rmbb_match.sv
rtl/core/rmbb_ctrl.sv
rtl/core/radio_module_baud_bringup_core.sv
bench/radio_module_baud_bringup_core_test.sv
